// ----- design/ljt_pkg.sv -----
// ----------------------------------------------------------------------------
// ljt_pkg: shared types and constants for the leg torque unit
// Fixed-point widths, CORDIC constants, arctangent table, register indexes.
// ----------------------------------------------------------------------------
package ljt_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ANG_W = 16;   // Q2.13 joint angle
	localparam int FRC_W = 24;   // force, 8 fraction bits
	localparam int LEN_W = 16;   // unsigned Q0.16 length
	localparam int TRQ_W = 32;   // torque, 8 fraction bits
	localparam int ZW    = 35;   // Q30 angle accumulator
	localparam int XY_W  = 34;   // CORDIC x / y in Q30
	localparam int SC_W  = 18;   // sine / cosine in Q16
	localparam int J_W   = 20;   // Jacobian entry in Q16

	localparam logic [LEN_W-1:0] ABAD_LEN_RST  = 16'd6095;
	localparam logic [LEN_W-1:0] THIGH_LEN_RST = 16'd9634;
	localparam logic [LEN_W-1:0] SHANK_LEN_RST = 16'd15073;

	localparam logic signed [ZW-1:0]   Q30_PI      = 35'sd3373259426;
	localparam logic signed [ZW-1:0]   Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [ZW-1:0]   Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [XY_W-1:0] Q30_GAIN    = 34'sd652032874;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ABAD_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THIGH_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHANK_LEN = 2'd2;

	typedef struct packed {
		logic signed [FRC_W-1:0] fx;
		logic signed [FRC_W-1:0] fy;
		logic signed [FRC_W-1:0] fz;
	} force_t;

	typedef struct packed {
		force_t f;
		logic   right;
	} tag_t;

	typedef struct packed {
		logic signed [SC_W-1:0] s;
		logic signed [SC_W-1:0] c;
	} sincos_t;

	typedef struct packed {
		logic signed [J_W-1:0] j12;
		logic signed [J_W-1:0] j13;
		logic signed [J_W-1:0] j21;
		logic signed [J_W-1:0] j22;
		logic signed [J_W-1:0] j23;
		logic signed [J_W-1:0] j31;
		logic signed [J_W-1:0] j32;
		logic signed [J_W-1:0] j33;
	} jac_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic signed [31:0] atan_q30(input int i);
		logic signed [31:0] r;
		case (i)
			0:  r = 32'sd843314856;
			1:  r = 32'sd497837829;
			2:  r = 32'sd263043836;
			3:  r = 32'sd133525158;
			4:  r = 32'sd67021686;
			5:  r = 32'sd33543515;
			6:  r = 32'sd16775850;
			7:  r = 32'sd8388437;
			8:  r = 32'sd4194282;
			9:  r = 32'sd2097149;
			10: r = 32'sd1048575;
			11: r = 32'sd524287;
			12: r = 32'sd262143;
			13: r = 32'sd131071;
			14: r = 32'sd65535;
			15: r = 32'sd32767;
			16: r = 32'sd16383;
			17: r = 32'sd8191;
			18: r = 32'sd4095;
			19: r = 32'sd2047;
			20: r = 32'sd1023;
			21: r = 32'sd511;
			22: r = 32'sd255;
			23: r = 32'sd127;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/leg_jacobian_transpose_torque_unit.sv -----
// ----------------------------------------------------------------------------
// leg_jacobian_transpose_torque_unit: joint torques of one leg, tau = J^T F
// Three CORDIC sine/cosine pipelines, Jacobian pipeline, torque pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         leg angles, foot force, right-leg flag
//  m_axis    out        abad, hip and knee torques
//  cfg       in         link length writes, indexes 0..2
//
//  One beat per cycle while m_axis is not stalled; each beat passes through
//  the sine/cosine pipelines, the Jacobian and the torque stage in order.
//  A stall on m_axis freezes every stage at once: s_axis_tready is low
//  exactly while a result waits unaccepted in the output register.
//  Reset clears valid bits and loads the default link lengths.
// ----------------------------------------------------------------------------
module leg_jacobian_transpose_torque_unit #(
	parameter int CORDIC_STEPS = ljt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// abad_angle, hip_angle, knee_angle, force_x, force_y, force_z
	input  logic [119:0]                      s_axis_tdata,
	// right_leg
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// abad_torque, hip_torque, knee_torque
	output logic [95:0]                       m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [ljt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ljt_pkg::LEN_W-1:0]         cfg_data
);
	import ljt_pkg::*;

	localparam int SC_LAT = CORDIC_STEPS + 3;

	logic en;
	logic [LEN_W-1:0] abad_len_q, thigh_len_q, shank_len_q;

	logic signed [ANG_W-1:0] q1, q2, q3;
	logic signed [ANG_W:0]   q23;
	logic signed [ZW-1:0]    ang1, ang2, ang23;
	tag_t                    tag_in;
	tag_t                    tag_q [0:SC_LAT-1];

	logic    v1, v2, v23;
	sincos_t sc1, sc2, sc23;
	logic    jv;
	jac_t    jac;
	force_t  jf;
	logic signed [TRQ_W-1:0] t_abad, t_hip, t_knee;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abad_len_q  <= ABAD_LEN_RST;
			thigh_len_q <= THIGH_LEN_RST;
			shank_len_q <= SHANK_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ABAD_LEN:  abad_len_q  <= cfg_data;
				REG_THIGH_LEN: thigh_len_q <= cfg_data;
				REG_SHANK_LEN: shank_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Q2.13 -> Q30
	always_comb begin
		q1     = $signed(s_axis_tdata[15:0]);
		q2     = $signed(s_axis_tdata[31:16]);
		q3     = $signed(s_axis_tdata[47:32]);
		q23    = {q2[ANG_W-1], q2} + {q3[ANG_W-1], q3};
		ang1   = {{(ZW-ANG_W-17){q1[ANG_W-1]}}, q1, 17'b0};
		ang2   = {{(ZW-ANG_W-17){q2[ANG_W-1]}}, q2, 17'b0};
		ang23  = {{(ZW-ANG_W-18){q23[ANG_W]}}, q23, 17'b0};
		tag_in.f.fx  = $signed(s_axis_tdata[71:48]);
		tag_in.f.fy  = $signed(s_axis_tdata[95:72]);
		tag_in.f.fz  = $signed(s_axis_tdata[119:96]);
		tag_in.right = s_axis_tuser;
	end

	// force and side ride alongside the sine/cosine pipelines
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag_in;
			for (int k = 1; k < SC_LAT; k++)
				tag_q[k] <= tag_q[k-1];
		end
	end

	ljt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(s_axis_tvalid),
		.angle(ang1), .vld_out(v1), .sc(sc1)
	);

	ljt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(s_axis_tvalid),
		.angle(ang2), .vld_out(v2), .sc(sc2)
	);

	ljt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc23 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(s_axis_tvalid),
		.angle(ang23), .vld_out(v23), .sc(sc23)
	);

	ljt_jacobian u_jac (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v1),
		.sc1(sc1), .sc2(sc2), .sc23(sc23), .tag_in(tag_q[SC_LAT-1]),
		.l1(abad_len_q), .l2(thigh_len_q), .l3(shank_len_q),
		.vld_out(jv), .jac(jac), .f_out(jf)
	);

	ljt_torque u_trq (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(jv),
		.jac(jac), .f(jf), .vld_out(m_axis_tvalid),
		.abad_torque(t_abad), .hip_torque(t_hip), .knee_torque(t_knee)
	);

	assign m_axis_tdata = {t_knee, t_hip, t_abad};

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(v1 == v2) && (v1 == v23))
		else $error("sine/cosine lanes out of step");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_THIGH_LEN) |=> (thigh_len_q == $past(cfg_data)))
		else $error("thigh length write lost");

endmodule

// ----- design/ljt_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// ljt_cordic_stage: one registered CORDIC rotation step
// Fixed shift per instance; rotation direction from the sign of z.
// ----------------------------------------------------------------------------
module ljt_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic signed [ljt_pkg::XY_W-1:0] x_in,
	input  logic signed [ljt_pkg::XY_W-1:0] y_in,
	input  logic signed [ljt_pkg::ZW-1:0]   z_in,
	input  logic                          neg_in,
	output logic                          vld_out,
	output logic signed [ljt_pkg::XY_W-1:0] x_out,
	output logic signed [ljt_pkg::XY_W-1:0] y_out,
	output logic signed [ljt_pkg::ZW-1:0]   z_out,
	output logic                          neg_out
);
	import ljt_pkg::*;

	localparam logic signed [31:0] ATAN = atan_q30(SHIFT);

	logic signed [XY_W-1:0] dx, dy, x_n, y_n;
	logic signed [ZW-1:0]   at, z_n;

	always_comb begin
		dx = y_in >>> SHIFT;
		dy = x_in >>> SHIFT;
		at = {{(ZW-32){ATAN[31]}}, ATAN};
		if (!z_in[ZW-1]) begin
			x_n = x_in - dx;
			y_n = y_in + dy;
			z_n = z_in - at;
		end else begin
			x_n = x_in + dx;
			y_n = y_in - dy;
			z_n = z_in + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out   <= x_n;
			y_out   <= y_n;
			z_out   <= z_n;
			neg_out <= neg_in;
		end
	end

endmodule

// ----- design/ljt_sincos.sv -----
// ----------------------------------------------------------------------------
// ljt_sincos: pipelined sine / cosine of a Q30 angle
// Two range-reduction stages, one stage per CORDIC step, one rounding stage.
// ----------------------------------------------------------------------------
module ljt_sincos #(
	parameter int CORDIC_STEPS = ljt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  logic signed [ljt_pkg::ZW-1:0] angle,
	output logic                        vld_out,
	output ljt_pkg::sincos_t            sc
);
	import ljt_pkg::*;

	logic                   v_s1, v_s2;
	logic signed [ZW-1:0]   z_s1, z_s2;
	logic                   neg_s2;

	logic                   v_c   [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] x_c   [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] y_c   [0:CORDIC_STEPS];
	logic signed [ZW-1:0]   z_c   [0:CORDIC_STEPS];
	logic                   neg_c [0:CORDIC_STEPS];

	logic signed [ZW-1:0]   z_w, z_f;
	logic                   neg_f;
	logic signed [XY_W-1:0] xr, yr;

	// wrap into [-pi, pi]
	always_comb begin
		if (angle > Q30_PI)
			z_w = angle - Q30_TWO_PI;
		else if (angle < -Q30_PI)
			z_w = angle + Q30_TWO_PI;
		else
			z_w = angle;
	end

	// fold into [-pi/2, pi/2], negate the result later
	always_comb begin
		neg_f = 1'b1;
		if (z_s1 > Q30_HALF_PI)
			z_f = z_s1 - Q30_PI;
		else if (z_s1 < -Q30_HALF_PI)
			z_f = z_s1 + Q30_PI;
		else begin
			z_f   = z_s1;
			neg_f = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			v_s1    <= vld_in;
			v_s2    <= v_s1;
			vld_out <= v_c[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= z_w;
			z_s2   <= z_f;
			neg_s2 <= neg_f;
		end
	end

	assign v_c[0]   = v_s2;
	assign x_c[0]   = Q30_GAIN;
	assign y_c[0]   = '0;
	assign z_c[0]   = z_s2;
	assign neg_c[0] = neg_s2;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		ljt_cordic_stage #(.SHIFT(k)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (v_c[k]),
			.x_in    (x_c[k]),
			.y_in    (y_c[k]),
			.z_in    (z_c[k]),
			.neg_in  (neg_c[k]),
			.vld_out (v_c[k+1]),
			.x_out   (x_c[k+1]),
			.y_out   (y_c[k+1]),
			.z_out   (z_c[k+1]),
			.neg_out (neg_c[k+1])
		);
	end

	// Q30 -> Q16, round half up
	always_comb begin
		xr = (neg_c[CORDIC_STEPS] ? -x_c[CORDIC_STEPS] : x_c[CORDIC_STEPS])
			+ XY_W'(8192);
		yr = (neg_c[CORDIC_STEPS] ? -y_c[CORDIC_STEPS] : y_c[CORDIC_STEPS])
			+ XY_W'(8192);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc.s <= yr[14 +: SC_W];
			sc.c <= xr[14 +: SC_W];
		end
	end

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out |-> (sc.c <= 18'sd65600 && sc.c >= -18'sd65600))
		else $error("cosine out of unit range");

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out |-> (sc.s <= 18'sd65600 && sc.s >= -18'sd65600))
		else $error("sine out of unit range");

endmodule

// ----- design/ljt_jacobian.sv -----
// ----------------------------------------------------------------------------
// ljt_jacobian: leg Jacobian entries from sines, cosines and link lengths
// Four stages: length products, sums, trig products, round to Q16.
// ----------------------------------------------------------------------------
module ljt_jacobian (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  ljt_pkg::sincos_t              sc1,
	input  ljt_pkg::sincos_t              sc2,
	input  ljt_pkg::sincos_t              sc23,
	input  ljt_pkg::tag_t                 tag_in,
	input  logic [ljt_pkg::LEN_W-1:0]     l1,
	input  logic [ljt_pkg::LEN_W-1:0]     l2,
	input  logic [ljt_pkg::LEN_W-1:0]     l3,
	output logic                          vld_out,
	output ljt_pkg::jac_t                 jac,
	output ljt_pkg::force_t               f_out
);
	import ljt_pkg::*;

	localparam int P1_W = LEN_W + 1 + SC_W;  // length times trig, Q32
	localparam int A_W  = P1_W + 1;
	localparam int P3_W = A_W + SC_W;        // Q48
	localparam int S4_W = P3_W + 2;

	logic v_s1, v_s2, v_s3;

	// stage 1
	logic signed [P1_W-1:0] l2c2_s1, l3c23_s1, l2s2_s1, l3s23_s1, l1s1_s1, l1c1_s1;
	sincos_t                sc1_s1;
	tag_t                   tag_s1;
	// stage 2
	logic signed [A_W-1:0]  a_s2, b_s2, t21_s2, t31_s2;
	logic signed [P1_W-1:0] l3s23_s2;
	logic signed [J_W-1:0]  j12_s2, j13_s2;
	sincos_t                sc1_s2;
	force_t                 f_s2;
	// stage 3
	logic signed [P3_W-1:0] ac1_s3, as1_s3, bs1_s3, bc1_s3, ss1_s3, sc1p_s3;
	logic signed [A_W-1:0]  t21_s3, t31_s3;
	logic signed [J_W-1:0]  j12_s3, j13_s3;
	force_t                 f_s3;

	logic signed [A_W-1:0]  a_n, b_n, ar, cr, l1s1_x, l1c1_x;
	logic signed [S4_W-1:0] s21, s22, s23, s31, s32, s33;

	localparam logic signed [S4_W-1:0] HALF32 = S4_W'(64'sd2147483648);

	function automatic logic signed [P1_W-1:0] lmul(input logic [LEN_W-1:0] l,
		input logic signed [SC_W-1:0] t);
		logic signed [LEN_W:0] ls;
		ls = $signed({1'b0, l});
		return P1_W'(ls * t);
	endfunction

	function automatic logic signed [S4_W-1:0] ext(input logic signed [P3_W-1:0] v);
		return {{(S4_W-P3_W){v[P3_W-1]}}, v};
	endfunction

	always_comb begin
		a_n    = {l2c2_s1[P1_W-1], l2c2_s1} + {l3c23_s1[P1_W-1], l3c23_s1};
		b_n    = {l2s2_s1[P1_W-1], l2s2_s1} + {l3s23_s1[P1_W-1], l3s23_s1};
		ar     = a_n + A_W'(32768);
		cr     = {l3c23_s1[P1_W-1], l3c23_s1} + A_W'(32768);
		l1s1_x = {l1s1_s1[P1_W-1], l1s1_s1};
		l1c1_x = {l1c1_s1[P1_W-1], l1c1_s1};
	end

	// offset terms already carry the leg side, shifted up to Q48 here
	always_comb begin
		s21 = {{(S4_W-A_W-16){t21_s3[A_W-1]}}, t21_s3, 16'b0} + ext(ac1_s3) + HALF32;
		s31 = {{(S4_W-A_W-16){t31_s3[A_W-1]}}, t31_s3, 16'b0} + ext(as1_s3) + HALF32;
		s22 = -ext(bs1_s3) + HALF32;
		s23 = -ext(ss1_s3) + HALF32;
		s32 = ext(bc1_s3) + HALF32;
		s33 = ext(sc1p_s3) + HALF32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			v_s1    <= vld_in;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			vld_out <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2c2_s1  <= lmul(l2, sc2.c);
			l3c23_s1 <= lmul(l3, sc23.c);
			l2s2_s1  <= lmul(l2, sc2.s);
			l3s23_s1 <= lmul(l3, sc23.s);
			l1s1_s1  <= lmul(l1, sc1.s);
			l1c1_s1  <= lmul(l1, sc1.c);
			sc1_s1   <= sc1;
			tag_s1   <= tag_in;

			a_s2     <= a_n;
			b_s2     <= b_n;
			t21_s2   <= tag_s1.right ? l1s1_x : -l1s1_x;
			t31_s2   <= tag_s1.right ? -l1c1_x : l1c1_x;
			l3s23_s2 <= l3s23_s1;
			j12_s2   <= ar[16 +: J_W];
			j13_s2   <= cr[16 +: J_W];
			sc1_s2   <= sc1_s1;
			f_s2     <= tag_s1.f;

			ac1_s3   <= P3_W'(a_s2 * sc1_s2.c);
			as1_s3   <= P3_W'(a_s2 * sc1_s2.s);
			bs1_s3   <= P3_W'(b_s2 * sc1_s2.s);
			bc1_s3   <= P3_W'(b_s2 * sc1_s2.c);
			ss1_s3   <= P3_W'(l3s23_s2 * sc1_s2.s);
			sc1p_s3  <= P3_W'(l3s23_s2 * sc1_s2.c);
			t21_s3   <= t21_s2;
			t31_s3   <= t31_s2;
			j12_s3   <= j12_s2;
			j13_s3   <= j13_s2;
			f_s3     <= f_s2;

			jac.j12  <= j12_s3;
			jac.j13  <= j13_s3;
			jac.j21  <= s21[32 +: J_W];
			jac.j22  <= s22[32 +: J_W];
			jac.j23  <= s23[32 +: J_W];
			jac.j31  <= s31[32 +: J_W];
			jac.j32  <= s32[32 +: J_W];
			jac.j33  <= s33[32 +: J_W];
			f_out    <= f_s3;
		end
	end

endmodule

// ----- design/ljt_torque.sv -----
// ----------------------------------------------------------------------------
// ljt_torque: Jacobian transpose times force
// One product stage, then sum, round to Q8 and the output register.
// ----------------------------------------------------------------------------
module ljt_torque (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  ljt_pkg::jac_t                 jac,
	input  ljt_pkg::force_t               f,
	output logic                          vld_out,
	output logic signed [ljt_pkg::TRQ_W-1:0] abad_torque,
	output logic signed [ljt_pkg::TRQ_W-1:0] hip_torque,
	output logic signed [ljt_pkg::TRQ_W-1:0] knee_torque
);
	import ljt_pkg::*;

	localparam int P_W = J_W + FRC_W;
	localparam int S_W = P_W + 2;
	localparam int R_W = S_W - 16;

	logic v_s1;
	logic signed [P_W-1:0] p12_s1, p13_s1, p21_s1, p22_s1, p23_s1, p31_s1, p32_s1, p33_s1;
	logic signed [S_W-1:0] t0, t1, t2;

	function automatic logic signed [S_W-1:0] ext(input logic signed [P_W-1:0] v);
		return {{(S_W-P_W){v[P_W-1]}}, v};
	endfunction

	// result of the rounding shift is R_W bits, so it always fits in 32
	function automatic logic signed [TRQ_W-1:0] to_q8(input logic signed [S_W-1:0] v);
		logic signed [R_W-1:0] r;
		r = v[16 +: R_W];
		return {{(TRQ_W-R_W){r[R_W-1]}}, r};
	endfunction

	always_comb begin
		t0 = ext(p21_s1) + ext(p31_s1) + S_W'(32768);
		t1 = ext(p12_s1) + ext(p22_s1) + ext(p32_s1) + S_W'(32768);
		t2 = ext(p13_s1) + ext(p23_s1) + ext(p33_s1) + S_W'(32768);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			v_s1    <= vld_in;
			vld_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p12_s1      <= P_W'(jac.j12 * f.fx);
			p13_s1      <= P_W'(jac.j13 * f.fx);
			p21_s1      <= P_W'(jac.j21 * f.fy);
			p22_s1      <= P_W'(jac.j22 * f.fy);
			p23_s1      <= P_W'(jac.j23 * f.fy);
			p31_s1      <= P_W'(jac.j31 * f.fz);
			p32_s1      <= P_W'(jac.j32 * f.fz);
			p33_s1      <= P_W'(jac.j33 * f.fz);
			abad_torque <= to_q8(t0);
			hip_torque  <= to_q8(t1);
			knee_torque <= to_q8(t2);
		end
	end

endmodule
